>>> sv/llrp_pkg.sv
// ============================================================================
// llrp_pkg - shared types and constants of the replica placer
// Sizes, field widths, status and register codes, and the command and
// status words between the controller and the datapath.
// ============================================================================
package llrp_pkg;

    localparam int MAX_NODES  = 16;
    localparam int MAX_SLOTS  = 16;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int SLOT_DEPTH = MAX_NODES * MAX_SLOTS;
    localparam int SLOT_AW    = NODE_W + SLOT_W;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 16;
    localparam int CNT_IDX_W  = $clog2(CNT_W);
    localparam int BYTES_W    = 48;
    localparam int SIZE_W     = 31;
    localparam int REM_W      = SLOT_W + 1;
    localparam int STATUS_W   = 2;
    localparam int SLOT_WORD_W = BYTES_W + CNT_W;

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    localparam logic [STATUS_W-1:0] STATUS_PLACED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_NODE = 2'd1;

    // Candidate order: home, ring predecessor, ring successor.
    localparam logic [1:0] CAND_HOME = 2'd0;
    localparam logic [1:0] CAND_PRED = 2'd1;
    localparam logic [1:0] CAND_SUCC = 2'd2;
    localparam logic [1:0] SCAN_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DIV,
        ST_SLOT_RD,
        ST_SLOT_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 capture;
        logic                 clear_all;
        logic                 res_short;
        logic                 node_rd;
        logic [1:0]           cand_sel;
        logic                 scan_take;
        logic                 scan_first;
        logic                 div_clear;
        logic                 div_step;
        logic [CNT_IDX_W-1:0] div_idx;
        logic                 slot_rd;
        logic                 slot_upd;
        logic                 out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_place;
        logic home_bad;
        logic out_busy;
    } t_dp_status;

    typedef struct packed {
        logic [NODE_W-1:0]   target_node;
        logic [SLOT_W-1:0]   slot_index;
        logic [BYTES_W-1:0]  slot_bytes;
        logic [CNT_W-1:0]    slot_chunks;
        logic [STATUS_W-1:0] status;
    } t_out_word;

endpackage

>>> sv/llrp_in_if.sv
// ============================================================================
// llrp_in_if - input channel of the replica placer
// Valid/ready channel carrying one place or clear word.
// ============================================================================
interface llrp_in_if import llrp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [NODE_W-1:0] home_node;
    logic [SIZE_W-1:0] chunk_size;

    modport source (output valid, output func, output home_node, output chunk_size,
                    input ready);
    modport sink (input valid, input func, input home_node, input chunk_size,
                  output ready);
endinterface

>>> sv/llrp_out_if.sv
// ============================================================================
// llrp_out_if - result channel of the replica placer
// Valid/ready channel carrying one placement result word.
// ============================================================================
interface llrp_out_if import llrp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [NODE_W-1:0]   target_node;
    logic [SLOT_W-1:0]   slot_index;
    logic [BYTES_W-1:0]  slot_bytes;
    logic [CNT_W-1:0]    slot_chunks;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output target_node, output slot_index,
                    output slot_bytes, output slot_chunks, output status,
                    input ready);
    modport sink (input valid, input target_node, input slot_index,
                  input slot_bytes, input slot_chunks, input status,
                  output ready);
endinterface

>>> sv/llrp_ram.sv
// ============================================================================
// llrp_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module llrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/llrp_ctrl.sv
// ============================================================================
// llrp_ctrl - sequencer of the replica placer
// Steps one word through check, candidate scan, slot division and update.
// ============================================================================
module llrp_ctrl import llrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state               r_state, n_state;
    logic [1:0]           r_k, n_k;
    logic [CNT_IDX_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= CAND_HOME;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.div_idx = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_status.is_place) begin
                    o_cmd.clear_all = 1'b1;
                    o_cmd.res_short = 1'b1;
                    n_state         = ST_DONE;
                end else if (i_status.home_bad) begin
                    o_cmd.res_short = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    o_cmd.node_rd  = 1'b1;
                    o_cmd.cand_sel = CAND_HOME;
                    n_k            = CAND_PRED;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Each cycle takes the load read last cycle and, until the successor is read, reads the next one.
                o_cmd.scan_take  = 1'b1;
                o_cmd.scan_first = (r_k == CAND_PRED);
                if (r_k == SCAN_LAST) begin
                    o_cmd.div_clear = 1'b1;
                    n_cnt           = CNT_IDX_W'(CNT_W - 1);
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.node_rd  = 1'b1;
                    o_cmd.cand_sel = r_k;
                    n_k            = r_k + 2'd1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SLOT_RD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SLOT_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = ST_SLOT_UPD;
            end
            ST_SLOT_UPD: begin
                o_cmd.slot_upd = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/llrp_dp.sv
// ============================================================================
// llrp_dp - datapath of the replica placer
// Configuration, counter memories with valid bits, candidate compare,
// bit-serial slot remainder, saturating update and the result register.
// ============================================================================
module llrp_dp import llrp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_func,
    input  logic [NODE_W-1:0]    i_home_node,
    input  logic [SIZE_W-1:0]    i_chunk_size,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word
);

    logic [CFG_W-1:0]      r_num_nodes, r_slots;
    logic                  r_func;
    logic [NODE_W-1:0]     r_home;
    logic [SIZE_W-1:0]     r_size;
    logic [MAX_NODES-1:0]  r_node_vld;
    logic [SLOT_DEPTH-1:0] r_slot_vld;
    logic                  r_node_rd_vld, r_slot_rd_vld;
    logic [NODE_W-1:0]     r_rd_node;
    logic [NODE_W-1:0]     r_best_node;
    logic [CNT_W-1:0]      r_best_load;
    logic [REM_W-1:0]      r_rem, n_rem;
    t_out_word             r_res;
    t_out_word             r_out;
    logic                  r_out_valid;

    logic [CFG_W-1:0]       n_eff, s_eff;
    logic [NODE_W-1:0]      cand_pred, cand_succ, cand;
    logic [CNT_W-1:0]       node_rdata, rd_load, node_inc;
    logic [SLOT_AW-1:0]     slot_addr;
    logic [SLOT_WORD_W-1:0] slot_rdata, slot_wdata;
    logic [BYTES_W-1:0]     old_bytes, new_bytes;
    logic [CNT_W-1:0]       old_chunks, new_chunks;
    logic [BYTES_W:0]       byte_sum;
    logic [REM_W-1:0]       rem_shift;

    // Out-of-range settings act as the nearest legal value.
    always_comb begin
        n_eff = r_num_nodes;
        if (r_num_nodes == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_num_nodes > CFG_W'(MAX_NODES)) begin
            n_eff = CFG_W'(MAX_NODES);
        end
        s_eff = r_slots;
        if (r_slots == '0) begin
            s_eff = CFG_W'(1);
        end else if (r_slots > CFG_W'(MAX_SLOTS)) begin
            s_eff = CFG_W'(MAX_SLOTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= CFG_W'(1);
            r_slots     <= CFG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NUM_NODES) begin
                r_num_nodes <= i_cfg_data;
            end else if (i_cfg_idx == REG_SLOTS_PER_NODE) begin
                r_slots <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_home <= i_home_node;
            r_size <= i_chunk_size;
        end
    end

    assign o_status.is_place = (r_func == FUNC_PLACE);
    assign o_status.home_bad = ({1'b0, r_home} >= n_eff);
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // Ring neighbors of the home node.
    always_comb begin
        if (r_home == '0) begin
            cand_pred = NODE_W'(n_eff - CFG_W'(1));
        end else begin
            cand_pred = r_home - 1'b1;
        end
        if (({1'b0, r_home} + CFG_W'(1)) >= n_eff) begin
            cand_succ = '0;
        end else begin
            cand_succ = r_home + 1'b1;
        end
        case (i_cmd.cand_sel)
            CAND_HOME: cand = r_home;
            CAND_PRED: cand = cand_pred;
            CAND_SUCC: cand = cand_succ;
            default:   cand = r_home;
        endcase
    end

    assign node_inc = (r_best_load == CNT_MAX) ? r_best_load : r_best_load + 1'b1;

    llrp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.slot_rd),
        .i_waddr (r_best_node),
        .i_wdata (node_inc),
        .i_re    (i_cmd.node_rd),
        .i_raddr (cand),
        .o_rdata (node_rdata)
    );

    assign rd_load = r_node_rd_vld ? node_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.node_rd) begin
            r_rd_node     <= cand;
            r_node_rd_vld <= r_node_vld[cand];
        end
        if (i_cmd.scan_take) begin
            if (i_cmd.scan_first || (rd_load < r_best_load)) begin
                r_best_node <= r_rd_node;
                r_best_load <= rd_load;
            end
        end
    end

    // Restoring remainder, one bit of the winning node's load count per cycle.
    always_comb begin
        rem_shift = {r_rem[SLOT_W-1:0], r_best_load[i_cmd.div_idx]};
        n_rem     = rem_shift;
        if (rem_shift >= REM_W'(s_eff)) begin
            n_rem = rem_shift - REM_W'(s_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_clear) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
    end

    assign slot_addr = {r_best_node, r_rem[SLOT_W-1:0]};

    llrp_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.slot_upd),
        .i_waddr (slot_addr),
        .i_wdata (slot_wdata),
        .i_re    (i_cmd.slot_rd),
        .i_raddr (slot_addr),
        .o_rdata (slot_rdata)
    );

    always_comb begin
        old_bytes  = r_slot_rd_vld ? slot_rdata[SLOT_WORD_W-1:CNT_W] : '0;
        old_chunks = r_slot_rd_vld ? slot_rdata[CNT_W-1:0] : '0;
        byte_sum   = {1'b0, old_bytes} + (BYTES_W + 1)'(r_size);
        new_bytes  = byte_sum[BYTES_W] ? BYTES_MAX : byte_sum[BYTES_W-1:0];
        new_chunks = (old_chunks == CNT_MAX) ? old_chunks : old_chunks + 1'b1;
        slot_wdata = {new_bytes, new_chunks};
    end

    // Valid bits stand in for the zeroed counters after reset or a clear word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_vld    <= '0;
            r_slot_vld    <= '0;
            r_slot_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_node_vld <= '0;
                r_slot_vld <= '0;
            end
            if (i_cmd.slot_rd) begin
                r_node_vld[r_best_node] <= 1'b1;
                r_slot_rd_vld           <= r_slot_vld[slot_addr];
            end
            if (i_cmd.slot_upd) begin
                r_slot_vld[slot_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_short) begin
            r_res.target_node <= '0;
            r_res.slot_index  <= '0;
            r_res.slot_bytes  <= '0;
            r_res.slot_chunks <= '0;
            r_res.status      <= (r_func == FUNC_CLEAR) ? STATUS_CLEARED : STATUS_RANGE;
        end else if (i_cmd.slot_upd) begin
            r_res.target_node <= r_best_node;
            r_res.slot_index  <= r_rem[SLOT_W-1:0];
            r_res.slot_bytes  <= new_bytes;
            r_res.slot_chunks <= new_chunks;
            r_res.status      <= STATUS_PLACED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> sv/least_loaded_replica_placer.sv
// ============================================================================
// least_loaded_replica_placer - least-loaded replica placement on a ring
// Picks the least-loaded of a chunk's home node and its two ring neighbors,
// assigns a slot on it and keeps saturating per-node and per-slot counters.
// ============================================================================
// The block takes one word at a time. A place word goes from acceptance to a
// loaded result in steps: a check of the word, reads of the three candidate
// loads out of the node-load memory through its single read port, the
// bit-serial remainder of the winning node's 16-bit count by the slot count,
// a read and a write-back of the slot counters, and the handoff of the result
// to the output register. A clear word or a word whose home node lies beyond
// the ring is checked and goes straight to the handoff. The input is ready
// again in the same cycle as the result sits in the output register, so the
// next word is taken while that result still waits for the sink; a result is
// only held back when the output register is still full. Clear words cost no
// sweep: every node and slot entry carries a valid bit that reset and a clear
// word drop all at once, and an entry without it reads as zero. Configuration
// writes (index 0 node count, index 1 slot count) are taken at any time but
// should be made only while the block is idle.
module least_loaded_replica_placer import llrp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    llrp_in_if.sink              i_in,
    llrp_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_out_word  out_word;
    logic       in_ready;
    logic       out_valid;

    // The sequencer owns the handshake on the input side.
    llrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds configuration, counters and the output register.
    llrp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_in.func),
        .i_home_node  (i_in.home_node),
        .i_chunk_size (i_in.chunk_size),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out.ready),
        .o_out_word   (out_word)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.target_node = out_word.target_node;
    assign o_out.slot_index  = out_word.slot_index;
    assign o_out.slot_bytes  = out_word.slot_bytes;
    assign o_out.slot_chunks = out_word.slot_chunks;
    assign o_out.status      = out_word.status;

endmodule

>>> sv/llrp_chk.sv
// ============================================================================
// llrp_chk - port-level checks of the replica placer
// Watches the channels of the top level and is bound to it below.
// ============================================================================
module llrp_chk import llrp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [NODE_W-1:0]   i_target_node,
    input logic [SLOT_W-1:0]   i_slot_index,
    input logic [BYTES_W-1:0]  i_slot_bytes,
    input logic [CNT_W-1:0]    i_slot_chunks,
    input logic [STATUS_W-1:0] i_status
);

    // One word at a time: the input closes right after a word is taken.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input stayed ready after a word was taken");

    // Clear and out-of-range results carry all-zero fields.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != STATUS_PLACED)) |->
        (i_target_node == '0 && i_slot_index == '0 &&
         i_slot_bytes == '0 && i_slot_chunks == '0))
        else $error("non-placement result has nonzero fields");

    // A placed chunk always leaves its slot with at least one chunk.
    a_placed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STATUS_PLACED)) |-> (i_slot_chunks != '0))
        else $error("placed result shows an empty slot");

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_target_node) && $stable(i_slot_index) &&
         $stable(i_slot_bytes) && $stable(i_slot_chunks) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind least_loaded_replica_placer llrp_chk u_llrp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_target_node (o_out.target_node),
    .i_slot_index  (o_out.slot_index),
    .i_slot_bytes  (o_out.slot_bytes),
    .i_slot_chunks (o_out.slot_chunks),
    .i_status      (o_out.status)
);
